// ----- rtl/plo_pkg.sv -----
// plo_pkg: shared types, codes and a helper function for the pixel layout offset block
// no dependencies; used by every module under rtl

package plo_pkg;

   // widths fixed by the register map and the item fields
   localparam int unsigned CoordW  = 12;
   localparam int unsigned DimW    = 13;
   localparam int unsigned LogW    = 4;
   localparam int unsigned OffW    = 24;
   localparam int unsigned ModeW   = 3;
   localparam int unsigned CsrIdxW = 2;

   // layout codes
   localparam logic [ModeW-1:0] LM_STRIDED = 3'd0;
   localparam logic [ModeW-1:0] LM_TILE8   = 3'd1;
   localparam logic [ModeW-1:0] LM_TILE16  = 3'd2;
   localparam logic [ModeW-1:0] LM_TILE32  = 3'd3;
   localparam logic [ModeW-1:0] LM_TWIDDLE = 3'd4;

   // register indexes
   localparam logic [CsrIdxW-1:0] REG_LAYOUT_MODE  = 2'd0;
   localparam logic [CsrIdxW-1:0] REG_IMAGE_WIDTH  = 2'd1;
   localparam logic [CsrIdxW-1:0] REG_IMAGE_HEIGHT = 2'd2;

   // reset values
   localparam logic [DimW-1:0] DIM_RESET = 13'd4096;
   localparam logic [LogW-1:0] LOG_RESET = 4'd12;

   // configuration as seen by the datapath, with the twiddle sizes precomputed
   typedef struct packed {
      logic [ModeW-1:0] mode;
      logic [DimW-1:0]  width;
      logic [LogW-1:0]  wlog;    // log2 of width rounded up to a power of two
      logic [LogW-1:0]  hlog;    // log2 of height rounded up to a power of two
      logic             wzero;   // width is zero
      logic             hzero;   // height is zero
   } plo_cfg_type;

   // ceil(log2(v)) for v >= 1, i.e. bit length of v-1
   function automatic logic [LogW-1:0] ceil_log2(input logic [DimW-1:0] v);
      logic [DimW-1:0] vm;
      logic [LogW-1:0] n;
      vm = v - DimW'(1);
      n  = '0;
      for (int i = 0; i < DimW; i++) begin
         if (vm[i]) begin
            n = LogW'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

// ----- rtl/pixel_layout_offset_core.sv -----
// pixel_layout_offset_core: top level of the pixel layout offset generator
// depends on plo_pkg, plo_cfg_regs and plo_offset_calc
//
//   channel   direction   handshake               payload
//   req       in          req_valid / req_ready   req_coord_x, req_coord_y
//   rsp       out         rsp_valid / rsp_ready   rsp_linear_offset
//   csr       in          csr_wen                 csr_index, csr_wdata
//
// one item per cycle sustained while rsp_ready stays high; an accepted item passes the coordinate
// register and then the offset register before rsp_valid rises
// latency is set by the coordinate register and the offset register around one multiplier
// reset is synchronous, active high, and restores strided layout with a 4096 x 4096 image
// when rsp is stalled the coordinate register still takes one more item, then req_ready drops
// req_ready follows rsp_ready combinationally only while both stages hold an item

module pixel_layout_offset_core (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [plo_pkg::CoordW-1:0]        req_coord_x,
   input  logic [plo_pkg::CoordW-1:0]        req_coord_y,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [plo_pkg::OffW-1:0]          rsp_linear_offset,

   input  logic                              csr_wen,
   input  logic [plo_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [plo_pkg::DimW-1:0]          csr_wdata
);

   plo_pkg::plo_cfg_type        cfg;

   // coordinate stage
   logic                        s1_vld_ff;
   logic                        s1_vld_in;
   logic [plo_pkg::CoordW-1:0]  x_ff;
   logic [plo_pkg::CoordW-1:0]  y_ff;

   // result stage
   logic                        rsp_vld_ff;
   logic                        rsp_vld_in;
   logic [plo_pkg::OffW-1:0]    offset_ff;
   logic [plo_pkg::OffW-1:0]    offset_in;

   logic                        out_free;
   logic                        req_take;
   logic                        s1_move;

   // configuration registers, with rounded twiddle sizes
   plo_cfg_regs u_cfg_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // offset arithmetic between the two registers
   plo_offset_calc u_offset_calc (
      .coord_x (x_ff),
      .coord_y (y_ff),
      .cfg     (cfg),
      .offset  (offset_in)
   );

   // result register empties or is being drained this cycle
   assign out_free  = !rsp_vld_ff || rsp_ready;
   // coordinate stage can take an item when empty or when it moves on
   assign req_ready = !s1_vld_ff || out_free;
   assign req_take  = req_valid && req_ready;
   assign s1_move   = s1_vld_ff && out_free;

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (req_ready) begin
         s1_vld_in = req_valid;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (out_free) begin
         rsp_vld_in = s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         x_ff <= req_coord_x;
         y_ff <= req_coord_y;
      end
      if (s1_move) begin
         offset_ff <= offset_in;
      end
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_linear_offset = offset_ff;

`ifndef SYNTHESIS
   // input side stalls only when both stages hold an item
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_vld_ff && rsp_vld_ff))
      else $error("req_ready low with a free stage");

   // a held coordinate item survives an output stall unchanged
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !out_free) |=> (s1_vld_ff && $stable(x_ff) && $stable(y_ff)))
      else $error("coordinate stage lost or changed an item under stall");

   // unknown layout codes give offset zero
   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_move && cfg.mode != plo_pkg::LM_STRIDED && cfg.mode != plo_pkg::LM_TILE8
       && cfg.mode != plo_pkg::LM_TILE16 && cfg.mode != plo_pkg::LM_TILE32
       && cfg.mode != plo_pkg::LM_TWIDDLE) |=> (rsp_linear_offset == '0))
      else $error("unknown layout gave a nonzero offset");

   // in 8 pixel tiles the low bits are the in-tile column and row
   a_tile8_low_bits: assert property (@(posedge clock) disable iff (reset)
      (s1_move && cfg.mode == plo_pkg::LM_TILE8) |=>
         (rsp_linear_offset[2:0] == $past(x_ff[2:0])
          && rsp_linear_offset[5:3] == $past(y_ff[2:0])))
      else $error("tile of 8 offset has wrong in-tile bits");
`endif

endmodule

// ----- rtl/plo_cfg_regs.sv -----
// plo_cfg_regs: configuration registers with twiddle size derivation at write time
// depends on plo_pkg

module plo_cfg_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [plo_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [plo_pkg::DimW-1:0]          csr_wdata,
   output plo_pkg::plo_cfg_type              cfg
);

   plo_pkg::plo_cfg_type cfg_ff;
   plo_pkg::plo_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            plo_pkg::REG_LAYOUT_MODE: begin
               cfg_in.mode = csr_wdata[plo_pkg::ModeW-1:0];
            end
            plo_pkg::REG_IMAGE_WIDTH: begin
               cfg_in.width = csr_wdata;
               cfg_in.wlog  = plo_pkg::ceil_log2(csr_wdata);
               cfg_in.wzero = (csr_wdata == '0);
            end
            plo_pkg::REG_IMAGE_HEIGHT: begin
               cfg_in.hlog  = plo_pkg::ceil_log2(csr_wdata);
               cfg_in.hzero = (csr_wdata == '0);
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode  <= plo_pkg::LM_STRIDED;
         cfg_ff.width <= plo_pkg::DIM_RESET;
         cfg_ff.wlog  <= plo_pkg::LOG_RESET;
         cfg_ff.hlog  <= plo_pkg::LOG_RESET;
         cfg_ff.wzero <= 1'b0;
         cfg_ff.hzero <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/plo_twiddle.sv -----
// plo_twiddle: morton (twiddled) offset, x bit above y bit, longer side remainder added
// depends on plo_pkg

module plo_twiddle (
   input  logic [plo_pkg::CoordW-1:0]  coord_x,
   input  logic [plo_pkg::CoordW-1:0]  coord_y,
   input  plo_pkg::plo_cfg_type        cfg,
   output logic [plo_pkg::OffW-1:0]    offset
);

   localparam int unsigned MortW = 2 * plo_pkg::DimW;

   logic [plo_pkg::LogW-1:0] levels;
   logic [plo_pkg::LogW-1:0] sx;
   logic [plo_pkg::LogW-1:0] sy;
   logic [plo_pkg::LogW:0]   lvl_gap;
   logic [plo_pkg::DimW:0]   xlim;
   logic [plo_pkg::DimW:0]   ylim;
   logic [plo_pkg::DimW-1:0] xs;
   logic [plo_pkg::DimW-1:0] ys;
   logic [plo_pkg::DimW-1:0] xh;
   logic [plo_pkg::DimW-1:0] yh;
   logic [MortW-1:0]         mort;
   logic [MortW-1:0]         mort_sh;
   logic [plo_pkg::DimW-1:0] xrem;
   logic [plo_pkg::DimW-1:0] yrem;
   logic [plo_pkg::OffW-1:0] tail;

   // interleave depth and how far each side reaches past it
   assign levels  = (cfg.wlog < cfg.hlog) ? cfg.wlog : cfg.hlog;
   assign sx      = cfg.wlog - levels;
   assign sy      = cfg.hlog - levels;
   assign lvl_gap = {1'b0, sx} + {1'b0, sy};

   // coordinates past the rounded size saturate: every level then takes its half
   assign xlim = ((plo_pkg::DimW+1)'(1) << cfg.wlog) - (plo_pkg::DimW+1)'(1);
   assign ylim = ((plo_pkg::DimW+1)'(1) << cfg.hlog) - (plo_pkg::DimW+1)'(1);
   assign xs   = ({2'b00, coord_x} > xlim) ? xlim[plo_pkg::DimW-1:0] : {1'b0, coord_x};
   assign ys   = ({2'b00, coord_y} > ylim) ? ylim[plo_pkg::DimW-1:0] : {1'b0, coord_y};
   assign xh   = xs >> sx;
   assign yh   = ys >> sy;

   always_comb begin
      for (int j = 0; j < plo_pkg::DimW; j++) begin
         mort[2*j+1] = xh[j];
         mort[2*j]   = yh[j];
      end
   end

   assign mort_sh = mort << lvl_gap;

   // what is left of the longer side after the interleaved levels
   assign xrem = {1'b0, coord_x} - (xh << sx);
   assign yrem = {1'b0, coord_y} - (yh << sy);

   always_comb begin
      if (cfg.wlog > cfg.hlog) begin
         tail = plo_pkg::OffW'(xrem);
      end else if (cfg.hlog > cfg.wlog) begin
         tail = plo_pkg::OffW'(yrem);
      end else begin
         tail = '0;
      end
   end

   always_comb begin
      if (cfg.wzero || cfg.hzero) begin
         // no interleave at all, only the other side counts
         if (cfg.wzero && !cfg.hzero && cfg.hlog != '0) begin
            offset = plo_pkg::OffW'(coord_y);
         end else if (cfg.hzero && !cfg.wzero && cfg.wlog != '0) begin
            offset = plo_pkg::OffW'(coord_x);
         end else begin
            offset = '0;
         end
      end else begin
         offset = mort_sh[plo_pkg::OffW-1:0] + tail;
      end
   end

endmodule

// ----- rtl/plo_offset_calc.sv -----
// plo_offset_calc: strided and tiled offsets on one shared multiplier, layout select
// depends on plo_pkg and plo_twiddle

module plo_offset_calc (
   input  logic [plo_pkg::CoordW-1:0]  coord_x,
   input  logic [plo_pkg::CoordW-1:0]  coord_y,
   input  plo_pkg::plo_cfg_type        cfg,
   output logic [plo_pkg::OffW-1:0]    offset
);

   localparam int unsigned ShW   = 3;
   localparam int unsigned MaskW = 5;
   localparam int unsigned ProdW = plo_pkg::DimW + plo_pkg::CoordW;

   logic [ShW-1:0]              tshift;
   logic [MaskW-1:0]            tmask;
   logic [plo_pkg::DimW:0]      tpr_sum;
   logic [plo_pkg::DimW-1:0]    tpr;
   logic [plo_pkg::CoordW-1:0]  yq;
   logic [plo_pkg::CoordW-1:0]  xq;
   logic [plo_pkg::CoordW-1:0]  ylow;
   logic [plo_pkg::CoordW-1:0]  xlow;
   logic [ProdW-1:0]            prod;
   logic [plo_pkg::OffW-1:0]    tile;
   logic [plo_pkg::OffW-1:0]    block_off;
   logic [plo_pkg::OffW-1:0]    twid_off;

   // strided is the degenerate case of a one pixel tile
   always_comb begin
      case (cfg.mode)
         plo_pkg::LM_TILE8:  tshift = 3'd3;
         plo_pkg::LM_TILE16: tshift = 3'd4;
         plo_pkg::LM_TILE32: tshift = 3'd5;
         default:            tshift = 3'd0;
      endcase
   end

   assign tmask   = (MaskW'(1) << tshift) - MaskW'(1);
   assign tpr_sum = {1'b0, cfg.width} + (plo_pkg::DimW+1)'(tmask);
   assign tpr     = plo_pkg::DimW'(tpr_sum >> tshift);
   assign yq      = coord_y >> tshift;
   assign xq      = coord_x >> tshift;
   assign ylow    = coord_y & plo_pkg::CoordW'(tmask);
   assign xlow    = coord_x & plo_pkg::CoordW'(tmask);

   assign prod = (ProdW'(tpr) * ProdW'(yq)) + ProdW'(xq);
   assign tile = prod[plo_pkg::OffW-1:0];

   // tile base sits above the in-tile row and column bits
   assign block_off = (tile << {tshift, 1'b0})
                    | (plo_pkg::OffW'(ylow) << tshift)
                    | plo_pkg::OffW'(xlow);

   plo_twiddle u_twiddle (
      .coord_x (coord_x),
      .coord_y (coord_y),
      .cfg     (cfg),
      .offset  (twid_off)
   );

   always_comb begin
      case (cfg.mode)
         plo_pkg::LM_STRIDED,
         plo_pkg::LM_TILE8,
         plo_pkg::LM_TILE16,
         plo_pkg::LM_TILE32:  offset = block_off;
         plo_pkg::LM_TWIDDLE: offset = twid_off;
         default:             offset = '0;
      endcase
   end

endmodule

// ----- bench/tb_pixel_layout_offset_core.sv -----
// tb_pixel_layout_offset_core: self-checking bench for the pixel layout offset generator
// depends on plo_pkg and pixel_layout_offset_core; predicts every offset and checks each result

module tb_pixel_layout_offset_core;
   timeunit 1ns;
   timeprecision 1ps;

   // run shape
   localparam int unsigned ITEMS_PER_PHASE = 567;   // three random phases, about 1700 items
   localparam int unsigned LATENCY_TAIL    = 4;     // settle wait after the bench queues drain
   localparam int unsigned LONG_STALL      = 400;   // receiver hold-off, in cycles
   localparam int unsigned STUCK_LIMIT     = 5000;  // cycles with work pending and no transfer
   localparam int unsigned MAX_REPORTS     = 100;

   // index with no register behind it, writes to it must change nothing
   localparam logic [plo_pkg::CsrIdxW-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [plo_pkg::CoordW-1:0] x;
      logic [plo_pkg::CoordW-1:0] y;
   } coord_pair_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // block ports; the inputs driven by the bench are known from time zero
   logic                        req_valid   = 1'b0;
   logic                        req_ready;
   logic [plo_pkg::CoordW-1:0]  req_coord_x = '0;
   logic [plo_pkg::CoordW-1:0]  req_coord_y = '0;
   logic                        rsp_valid;
   logic                        rsp_ready   = 1'b0;
   logic [plo_pkg::OffW-1:0]    rsp_linear_offset;
   logic                        csr_wen     = 1'b0;
   logic [plo_pkg::CsrIdxW-1:0] csr_index   = '0;
   logic [plo_pkg::DimW-1:0]    csr_wdata   = '0;

   pixel_layout_offset_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_linear_offset (rsp_linear_offset),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // bench copy of the register file, starts at the reset values
   logic [plo_pkg::ModeW-1:0] cur_mode   = plo_pkg::LM_STRIDED;
   logic [plo_pkg::DimW-1:0]  cur_width  = plo_pkg::DIM_RESET;
   logic [plo_pkg::DimW-1:0]  cur_height = plo_pkg::DIM_RESET;

   coord_pair_type           coord_q[$];    // items waiting to be offered
   logic [plo_pkg::OffW-1:0] offset_q[$];   // predicted offsets, oldest first

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned stall_tokens  = 0; // bumped by the sequencer, each bump asks for one long hold-off

   int unsigned error_count      = 0;
   int unsigned items_accepted   = 0;
   int unsigned offsets_checked  = 0;
   int unsigned settings_applied = 0;

   // ------------------------------------------------------------------
   // offset prediction
   // ------------------------------------------------------------------

   // round up to a power of two; zero stays zero, 13-bit values give at most 8192
   function automatic logic [plo_pkg::DimW:0] pow2_ceil(input logic [plo_pkg::DimW-1:0] v);
      logic [plo_pkg::DimW:0] p;
      p = '0;
      if ((v & (v - 1'b1)) == '0) begin
         p = {1'b0, v};
      end else begin
         for (int i = 0; i < plo_pkg::DimW; i++) begin
            if (v[i]) begin
               p = (plo_pkg::DimW+1)'(1) << (i + 1);
            end
         end
      end
      return p;
   endfunction

   // square tiles of 2^shift pixels, tiles row-major over whole tiles per row
   function automatic logic [plo_pkg::OffW-1:0] tiled_offset(
         input logic [plo_pkg::CoordW-1:0] x,
         input logic [plo_pkg::CoordW-1:0] y,
         input logic [plo_pkg::DimW-1:0]   width,
         input int unsigned                shift);
      logic [31:0] side, mask, per_row, tile_idx, off;
      side     = 32'd1 << shift;
      mask     = side - 32'd1;
      per_row  = (32'(width) + mask) >> shift;
      tile_idx = per_row * (32'(y) >> shift) + (32'(x) >> shift);
      off      = tile_idx * side * side + side * (32'(y) & mask) + (32'(x) & mask);
      return off[plo_pkg::OffW-1:0];
   endfunction

   // morton order, x bit above y bit; leftover of the longer side added linearly
   function automatic logic [plo_pkg::OffW-1:0] twiddled_offset(
         input logic [plo_pkg::CoordW-1:0] x,
         input logic [plo_pkg::CoordW-1:0] y,
         input logic [plo_pkg::DimW-1:0]   width,
         input logic [plo_pkg::DimW-1:0]   height);
      logic [31:0] w, h, xr, yr, off;
      w   = 32'(pow2_ceil(width));
      h   = 32'(pow2_ceil(height));
      xr  = 32'(x);
      yr  = 32'(y);
      off = '0;
      while (w > 32'd1 && h > 32'd1) begin
         w = w >> 1;
         h = h >> 1;
         // each level takes its half size off at most once
         if (xr >= w) begin
            xr  = xr - w;
            off = off + 32'd2 * w * h;
         end
         if (yr >= h) begin
            yr  = yr - h;
            off = off + w * h;
         end
      end
      if (w > 32'd1) begin
         off = off + xr;
      end else if (h > 32'd1) begin
         off = off + yr;
      end
      return off[plo_pkg::OffW-1:0];
   endfunction

   function automatic logic [plo_pkg::OffW-1:0] layout_offset(
         input logic [plo_pkg::CoordW-1:0] x,
         input logic [plo_pkg::CoordW-1:0] y);
      logic [31:0] strided;
      strided = 32'(cur_width) * 32'(y) + 32'(x);
      case (cur_mode)
         plo_pkg::LM_STRIDED: return strided[plo_pkg::OffW-1:0];
         plo_pkg::LM_TILE8:   return tiled_offset(x, y, cur_width, 3);
         plo_pkg::LM_TILE16:  return tiled_offset(x, y, cur_width, 4);
         plo_pkg::LM_TILE32:  return tiled_offset(x, y, cur_width, 5);
         plo_pkg::LM_TWIDDLE: return twiddled_offset(x, y, cur_width, cur_height);
         default:             return '0;  // unknown layouts give offset zero
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      if (error_count < MAX_REPORTS) begin
         $display("%0t mismatch: %s", $realtime, what);
      end
      error_count++;
   endtask

   // ------------------------------------------------------------------
   // request driver: offers queued items, predicts each one as it is accepted
   // ------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      coord_pair_type nxt;
      logic           fire;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         fire = req_valid && req_ready;
         if (fire) begin
            // payload still holds the accepted item at this edge
            offset_q.push_back(layout_offset(req_coord_x, req_coord_y));
            items_accepted++;
         end
         // valid only drops after acceptance, payload stays put while waiting
         if (!req_valid || fire) begin
            if (coord_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = coord_q.pop_front();
               req_valid   <= 1'b1;
               req_coord_x <= nxt.x;
               req_coord_y <= nxt.y;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // response monitor: checks offsets in order and drives rsp_ready,
   // including the long hold-off that backs the block up into its input
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      logic [plo_pkg::OffW-1:0] want;
      int unsigned              hold_left;
      int unsigned              stall_seen;
      if (reset) begin
         rsp_ready  <= 1'b0;
         hold_left  = 0;
         stall_seen = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (offset_q.size() == 0) begin
               report_mismatch($sformatf("offset %0d with nothing expected", rsp_linear_offset));
            end else begin
               want = offset_q.pop_front();
               offsets_checked++;
               if (rsp_linear_offset !== want) begin
                  report_mismatch($sformatf("linear_offset got %0d want %0d",
                                            rsp_linear_offset, want));
               end
            end
         end
         if (stall_seen != stall_tokens) begin
            stall_seen = stall_tokens;
            hold_left  = LONG_STALL;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------------
   // watchdog: work pending but no transfer on either channel for too long
   // ------------------------------------------------------------------
   always @(posedge clock) begin : stuck_watch
      int unsigned stuck;
      if (reset) begin
         stuck = 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (coord_q.size() == 0 && !req_valid && offset_q.size() == 0)) begin
            stuck = 0;
         end else begin
            stuck++;
         end
         if (stuck >= STUCK_LIMIT) begin
            $display("watchdog: no progress for %0d cycles, %0d offsets outstanding",
                     stuck, offset_q.size());
            $display("tb_pixel_layout_offset_core: done, errors");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------

   // sender holds back until every predicted offset has come out
   task automatic wait_idle();
      while (coord_q.size() != 0 || req_valid || offset_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (LATENCY_TAIL) @(negedge clock);
   endtask

   // write all three registers back to back, optionally then the unused index; mode carries junk in its unused bits
   task automatic apply_setting(input logic [plo_pkg::ModeW-1:0] mode,
                                input logic [plo_pkg::DimW-1:0]  w,
                                input logic [plo_pkg::DimW-1:0]  h,
                                input logic                      poke_unused);
      wait_idle();
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= plo_pkg::REG_LAYOUT_MODE;
      csr_wdata <= {(plo_pkg::DimW-plo_pkg::ModeW)'($urandom_range(1023)), mode};
      @(posedge clock);
      csr_index <= plo_pkg::REG_IMAGE_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= plo_pkg::REG_IMAGE_HEIGHT;
      csr_wdata <= h;
      if (poke_unused) begin
         @(posedge clock);
         csr_index <= REG_UNUSED;
         csr_wdata <= plo_pkg::DimW'($urandom_range(8191));
      end
      @(posedge clock);
      csr_wen <= 1'b0;
      cur_mode   = mode;
      cur_width  = w;
      cur_height = h;
      settings_applied++;
   endtask

   task automatic queue_coord(input int unsigned x, input int unsigned y);
      coord_pair_type c;
      c.x = plo_pkg::CoordW'(x);
      c.y = plo_pkg::CoordW'(y);
      coord_q.push_back(c);
   endtask

   // small sizes most often, plus zero, one, powers of two, random and oversized values
   function automatic logic [plo_pkg::DimW-1:0] random_dim();
      case ($urandom_range(9))
         0:       return plo_pkg::DimW'(0);
         1:       return plo_pkg::DimW'(1);
         2:       return plo_pkg::DimW'(8191);
         3:       return plo_pkg::DIM_RESET;
         4:       return plo_pkg::DimW'(1) << $urandom_range(12);
         5:       return plo_pkg::DimW'($urandom_range(8191));
         default: return plo_pkg::DimW'($urandom_range(1, 200));
      endcase
   endfunction

   // one random setting followed by a burst of items; returns the item count
   task automatic random_segment(input logic hold_off, output int unsigned sent);
      logic [plo_pkg::ModeW-1:0] mode;
      logic [plo_pkg::DimW-1:0]  w, h;
      int unsigned               lim_x, lim_y, r;
      mode = ($urandom_range(9) < 9) ? plo_pkg::ModeW'($urandom_range(4))
                                     : plo_pkg::ModeW'($urandom_range(5, 7));
      w    = random_dim();
      h    = random_dim();
      apply_setting(mode, w, h, $urandom_range(7) == 0);
      if (hold_off) begin
         stall_tokens <= stall_tokens + 1;
      end
      lim_x = (w == 0 || w > 4096) ? 4096 : w;
      lim_y = (h == 0 || h > 4096) ? 4096 : h;
      sent  = hold_off ? 80 : $urandom_range(30, 70);
      for (int i = 0; i < sent; i++) begin
         r = $urandom_range(99);
         if (r < 60) begin
            // inside the image
            queue_coord($urandom_range(lim_x - 1), $urandom_range(lim_y - 1));
         end else if (r < 70) begin
            // corners of the coordinate range
            queue_coord($urandom_range(1) * 4095, $urandom_range(1) * 4095);
         end else begin
            queue_coord($urandom_range(4095), $urandom_range(4095));
         end
      end
   endtask

   initial begin : sequencer
      int unsigned phase_items, burst;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: reset setting, strided 4096 wide, including the largest offset
      queue_coord(0, 0);
      queue_coord(4095, 4095);
      queue_coord(4095, 0);
      queue_coord(0, 4095);

      // tiles of 8 on a narrow image, a point far outside it
      apply_setting(plo_pkg::LM_TILE8, 13'd100, 13'd50, 1'b0);
      queue_coord(7, 7);
      queue_coord(8, 0);
      queue_coord(99, 49);
      queue_coord(4095, 4095);

      // tiles of 16 on a one-pixel image
      apply_setting(plo_pkg::LM_TILE16, 13'd1, 13'd1, 1'b0);
      queue_coord(0, 0);
      queue_coord(17, 33);

      // tiles of 32 with the largest register values
      apply_setting(plo_pkg::LM_TILE32, 13'd8191, 13'd8191, 1'b1);
      queue_coord(4095, 4095);
      queue_coord(31, 31);

      // twiddled, wide then tall, coordinates inside and outside
      apply_setting(plo_pkg::LM_TWIDDLE, 13'd64, 13'd16, 1'b0);
      queue_coord(63, 15);
      queue_coord(5, 3);
      queue_coord(100, 40);
      apply_setting(plo_pkg::LM_TWIDDLE, 13'd16, 13'd64, 1'b0);
      queue_coord(15, 63);
      queue_coord(40, 100);

      // twiddled with zero width, a single pixel, and oversized dimensions
      apply_setting(plo_pkg::LM_TWIDDLE, 13'd0, 13'd64, 1'b0);
      queue_coord(7, 9);
      apply_setting(plo_pkg::LM_TWIDDLE, 13'd1, 13'd1, 1'b0);
      queue_coord(3, 3);
      apply_setting(plo_pkg::LM_TWIDDLE, 13'd8191, 13'd4097, 1'b0);
      queue_coord(4095, 4095);

      // strided with zero width
      apply_setting(plo_pkg::LM_STRIDED, 13'd0, 13'd10, 1'b0);
      queue_coord(9, 9);

      // unknown layout codes
      for (int m = plo_pkg::LM_TWIDDLE + 1; m < 8; m++) begin
         apply_setting(plo_pkg::ModeW'(m), 13'd33, 13'd33, 1'b0);
         queue_coord(1, 1);
      end

      // random, phase 1: sender idles a little, receiver a lot
      wait_idle();
      send_idle_pct = 14;
      recv_idle_pct = 77;
      phase_items   = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
         random_segment(1'b0, burst);
         phase_items += burst;
      end

      // phase 2: the other way round
      wait_idle();
      send_idle_pct = 77;
      recv_idle_pct = 14;
      phase_items   = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
         random_segment(1'b0, burst);
         phase_items += burst;
      end

      // phase 3: full rate both ways, starting with a long receiver hold-off
      // so the block backs up and drops req_ready while items keep coming
      wait_idle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_segment(1'b1, burst);
      phase_items = burst;
      while (phase_items < ITEMS_PER_PHASE) begin
         random_segment(1'b0, burst);
         phase_items += burst;
      end

      // drain, then keep watching to catch any stray result
      wait_idle();
      repeat (4 * LATENCY_TAIL) @(negedge clock);

      $display("summary: %0d items accepted, %0d offsets checked, %0d register settings",
               items_accepted, offsets_checked, settings_applied);
      $display("summary: all layouts incl. unknown codes, zero/one/oversized sizes, stalls");
      if (error_count == 0) begin
         $display("tb_pixel_layout_offset_core: done, clean");
      end else begin
         $display("tb_pixel_layout_offset_core: done, errors");
      end
      $finish;
   end

endmodule
